// ----- hdl/utf8_to_ucs2_decoder_assert.svh -----
// ----------------------------------------------------------------------------
// UTF-8 decoder assertion macros
// Concurrent assertion shorthands, sampled on clk_i, disabled during reset.
// ----------------------------------------------------------------------------
`ifndef UTF8_TO_UCS2_DECODER_ASSERT_SVH
`define UTF8_TO_UCS2_DECODER_ASSERT_SVH

// Same-cycle implication.
`define U8U2_ASSERT_NOW(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("assertion failed");

// Next-cycle implication.
`define U8U2_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

// ----- hdl/u8u2dec_pkg.sv -----
// ----------------------------------------------------------------------------
// UTF-8 decoder package
// Shared types, byte-class constants and helpers of the decoder.
// ----------------------------------------------------------------------------
package u8u2dec_pkg;

  localparam int unsigned PartW = 21;

  localparam logic [7:0]  AsciiMax   = 8'h7F;
  localparam logic [15:0] Replace    = 16'hFFFD;
  localparam logic [15:0] InvalidCp  = 16'h0000;
  localparam logic [1:0]  ContTag    = 2'b10;

  typedef struct packed {
    logic [15:0] code_point;
    logic        last_of_run;
  } result_t;

  // Results produced for one accepted byte.
  typedef struct packed {
    logic [1:0] n_res;
    result_t    res0;
    result_t    res1;
  } step_t;

  typedef struct packed {
    logic room;   // space for two more results
    logic busy;   // at least one result waiting
  } rbuf_stat_t;

  // Code points at or above U+10000 collapse to zero.
  function automatic logic [15:0] bmp_only(logic [PartW-1:0] code);
    logic [15:0] r;
    r = (code[PartW-1:16] == '0) ? code[15:0] : InvalidCp;
    return r;
  endfunction

endpackage

// ----- hdl/u8u2dec_if.sv -----
// ----------------------------------------------------------------------------
// UTF-8 decoder stream interfaces
// Valid/ready channels for input bytes and decoded code points.
// ----------------------------------------------------------------------------
interface u8u2dec_byte_if;
  logic       valid;
  logic       ready;
  logic [7:0] byte_in;

  modport source (output valid, output byte_in, input ready);
  modport sink   (input valid, input byte_in, output ready);
endinterface

interface u8u2dec_code_if;
  logic        valid;
  logic        ready;
  logic [15:0] code_point;
  logic        last_of_run;

  modport source (output valid, output code_point, output last_of_run, input ready);
  modport sink   (input valid, input code_point, input last_of_run, output ready);
endinterface

// ----- hdl/utf8_to_ucs2_decoder.sv -----
// ----------------------------------------------------------------------------
// UTF-8 to UCS-2 decoder
// Byte-stream UTF-8 decoder that keeps Basic Multilingual Plane code points.
// ----------------------------------------------------------------------------
// One UTF-8 byte is taken per beat on byte_i and decoded in the same cycle;
// its results land in a three-entry result queue and show on code_o from
// the next cycle on. With the sink always ready the block sustains one byte
// per cycle, except where a byte gives two results. A byte that breaks a
// pending sequence and is itself a complete lead gives two results (0xFFFD,
// then the lead's result); the queue then holds two entries and byte_i.ready
// drops while the extra result drains. byte_i.ready is high whenever the
// queue holds at most one result, so it depends only on registered state.
// Code points of U+10000 and above, lone continuation bytes, 0xC0/0xC1 and
// leads from 0xF5 up give 0. A NUL inside a sequence flushes the partial
// code. last_of_run marks the final result of each byte. Overlong forms and
// surrogates pass unchecked.
// ----------------------------------------------------------------------------
`include "utf8_to_ucs2_decoder_assert.svh"

module utf8_to_ucs2_decoder (
  input  logic            clk_i,
  input  logic            rst_ni,
  u8u2dec_byte_if.sink    byte_i,
  u8u2dec_code_if.source  code_o
);
  import u8u2dec_pkg::*;

  step_t      step;
  rbuf_stat_t stat;
  logic       accept;

  // Ready only on queue room: keeps ready off the valid path.
  assign byte_i.ready = stat.room;
  assign accept       = byte_i.valid && byte_i.ready;

  // Sequence state plus byte decode.
  u8u2dec_step u_step (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .accept_i  (accept),
    .byte_in_i (byte_i.byte_in),
    .step_o    (step)
  );

  // Result queue; also the output register.
  u8u2dec_rbuf u_rbuf (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (accept),
    .step_i (step),
    .stat_o (stat),
    .code_o (code_o)
  );

  // A beat that produces results must show them on the next cycle.
  `U8U2_ASSERT_NEXT(a_res_visible, accept && (step.n_res != 2'd0), code_o.valid)
  // Input only stalls when results are waiting.
  `U8U2_ASSERT_NOW(a_stall_needs_data, !byte_i.ready, code_o.valid && stat.busy)
  // Only the second of a pair can close the run; the first never does.
  `U8U2_ASSERT_NOW(a_pair_order, accept && (step.n_res == 2'd2),
                   !step.res0.last_of_run && step.res1.last_of_run)

endmodule

// ----- hdl/u8u2dec_step.sv -----
// ----------------------------------------------------------------------------
// UTF-8 decoder step
// Sequence state and combinational byte classification.
// ----------------------------------------------------------------------------
module u8u2dec_step (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                accept_i,
  input  logic [7:0]          byte_in_i,
  output u8u2dec_pkg::step_t  step_o
);
  import u8u2dec_pkg::*;

  logic [1:0]       pend_q, pend_d;
  logic [PartW-1:0] part_q, part_d;

  logic             lead_res;
  logic [15:0]      lead_cp;
  logic [1:0]       lead_pend;
  logic [PartW-1:0] lead_part;
  logic [PartW-1:0] cont_part;
  logic [1:0]       cont_pend;

  // Lead byte classification.
  always_comb begin
    lead_res  = 1'b0;
    lead_cp   = InvalidCp;
    lead_pend = 2'd0;
    lead_part = '0;
    unique case (byte_in_i) inside
      [8'h00:8'h7F]: begin
        lead_res = 1'b1;
        lead_cp  = {8'h00, byte_in_i};
      end
      [8'h80:8'hC1], [8'hF5:8'hFF]: begin
        lead_res = 1'b1;
      end
      [8'hC2:8'hDF]: begin
        lead_pend = 2'd1;
        lead_part = {{(PartW-5){1'b0}}, byte_in_i[4:0]};
      end
      [8'hE0:8'hEF]: begin
        lead_pend = 2'd2;
        lead_part = {{(PartW-4){1'b0}}, byte_in_i[3:0]};
      end
      [8'hF0:8'hF4]: begin
        lead_pend = 2'd3;
        lead_part = {{(PartW-3){1'b0}}, byte_in_i[2:0]};
      end
      default: begin
        lead_res = 1'b1;
      end
    endcase
  end

  assign cont_part = {part_q[PartW-7:0], byte_in_i[5:0]};
  assign cont_pend = pend_q - 2'd1;

  always_comb begin
    pend_d = pend_q;
    part_d = part_q;
    step_o = '0;
    if (pend_q == 2'd0) begin
      if (lead_res) begin
        step_o.n_res = 2'd1;
        step_o.res0  = '{code_point: lead_cp, last_of_run: 1'b1};
      end else begin
        pend_d = lead_pend;
        part_d = lead_part;
      end
    end else if (byte_in_i == 8'h00) begin
      // NUL cuts the sequence short and flushes what was gathered
      pend_d       = 2'd0;
      step_o.n_res = 2'd1;
      step_o.res0  = '{code_point: bmp_only(part_q), last_of_run: 1'b1};
    end else if (byte_in_i[7:6] == ContTag) begin
      pend_d = cont_pend;
      part_d = cont_part;
      if (cont_pend == 2'd0) begin
        step_o.n_res = 2'd1;
        step_o.res0  = '{code_point: bmp_only(cont_part), last_of_run: 1'b1};
      end
    end else begin
      // broken sequence: replacement first, then the byte as a new lead
      pend_d = lead_pend;
      part_d = lead_part;
      step_o.res0 = '{code_point: Replace, last_of_run: !lead_res};
      if (lead_res) begin
        step_o.n_res = 2'd2;
        step_o.res1  = '{code_point: lead_cp, last_of_run: 1'b1};
      end else begin
        step_o.n_res = 2'd1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pend_q <= 2'd0;
      part_q <= '0;
    end else if (accept_i) begin
      pend_q <= pend_d;
      part_q <= part_d;
    end
  end

endmodule

// ----- hdl/u8u2dec_rbuf.sv -----
// ----------------------------------------------------------------------------
// UTF-8 decoder result buffer
// Three-entry result queue; takes up to two results per beat.
// ----------------------------------------------------------------------------
module u8u2dec_rbuf (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     push_i,
  input  u8u2dec_pkg::step_t       step_i,
  output u8u2dec_pkg::rbuf_stat_t  stat_o,
  u8u2dec_code_if.source           code_o
);
  import u8u2dec_pkg::*;

  localparam logic [1:0] Depth = 2'd3;

  function automatic logic [1:0] nxt3(logic [1:0] p);
    logic [1:0] r;
    r = (p == Depth - 2'd1) ? 2'd0 : p + 2'd1;
    return r;
  endfunction

  result_t    mem_q [3];
  logic [1:0] wptr_q, wptr_d;
  logic [1:0] rptr_q, rptr_d;
  logic [1:0] cnt_q, cnt_d;
  logic [1:0] n_push;
  logic       pop;

  assign n_push = push_i ? step_i.n_res : 2'd0;
  assign pop    = code_o.valid && code_o.ready;

  always_comb begin
    cnt_d  = cnt_q + n_push - {1'b0, pop};
    rptr_d = pop ? nxt3(rptr_q) : rptr_q;
    case (n_push)
      2'd1:    wptr_d = nxt3(wptr_q);
      2'd2:    wptr_d = nxt3(nxt3(wptr_q));
      default: wptr_d = wptr_q;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q <= 2'd0;
      rptr_q <= 2'd0;
      cnt_q  <= 2'd0;
    end else begin
      wptr_q <= wptr_d;
      rptr_q <= rptr_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (n_push != 2'd0) begin
      mem_q[wptr_q] <= step_i.res0;
    end
    if (n_push == 2'd2) begin
      mem_q[nxt3(wptr_q)] <= step_i.res1;
    end
  end

  assign code_o.valid       = (cnt_q != 2'd0);
  assign code_o.code_point  = mem_q[rptr_q].code_point;
  assign code_o.last_of_run = mem_q[rptr_q].last_of_run;

  assign stat_o.room = (cnt_q <= 2'd1);
  assign stat_o.busy = (cnt_q != 2'd0);

endmodule
